// ----- src/phsh_pkg.sv -----
// Shared types, constants and hash key helpers for the header hash block.
package phsh_pkg;

  localparam int unsigned DefaultMaxNest = 4;
  localparam logic [15:0] DEF_SRC_PORT = 16'hFDFF;
  localparam logic [15:0] DEF_DST_PORT = 16'hFEFF;
  localparam int unsigned KeyWindows = 96;
  localparam int unsigned QueueDepth = 4;

  localparam logic [319:0] HASH_KEY = {
    64'h506d506d506d506d, 64'h506d506d506d506d,
    64'hcb2b5a5ab4307bae, 64'ha32dcb770cf23080, 64'h3bb7426afa01acbe};

  localparam logic [1:0] KIND_PORTS = 2'd0;
  localparam logic [1:0] KIND_ADDR  = 2'd1;
  localparam logic [1:0] KIND_MAC   = 2'd2;

  localparam logic [0:0] CFG_ADDRESSES_ONLY = 1'd0;
  localparam logic [0:0] CFG_PORT_SEED      = 1'd1;

  typedef enum logic [3:0] {
    PH_ETH, PH_VLAN, PH_IP4, PH_IP6, PH_PORTS,
    PH_DONE_PORTS, PH_DONE_ADDR, PH_DONE_MAC
  } phase_t;

  // Tuple handed from the parser to the hash engine.
  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [1:0]  kind;
    logic        truncated;
  } tuple_t;

  // Key window w: 32 key bits starting at bit position w (MSB first).
  function automatic logic [31:0] key_window(input int unsigned w);
    logic [31:0] v;
    int unsigned pos;
    v = '0;
    for (int unsigned b = 0; b < 32; b++) begin
      pos = (w + b) % 128;
      v[31-b] = (pos < 320) ? HASH_KEY[319-pos] : 1'b0;
    end
    return v;
  endfunction

endpackage

// ----- src/phsh_stream_if.sv -----
// Valid/ready channel carrying a packed payload.
interface phsh_stream_if #(parameter int unsigned W = 9);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- src/packet_header_symmetric_hash.sv -----
// Top level: frame header parser, tuple queue and Toeplitz hash engine.
//
// Usage: frame bytes enter on the in_ channel (payload {data_byte, last_byte}),
// one transfer per byte starting at the destination MAC. After the transfer
// that carries last_byte the block emits one result on the out_ channel
// (payload {hash_value, tuple_kind, truncated}).
// Throughput: one byte per cycle while the tuple queue has room. Path: the edge
// that takes the last byte writes the tuple queue, then the hash XOR stage
// registers the result, then the output register raises out_valid.
// The parser keeps pace with the link; a four-entry tuple queue decouples it
// from the hash engine. in_ready drops only when that queue is full, which
// happens if the receiver stalls out_ready across several frame ends.
// Configuration: cfg_we writes cfg_data to register cfg_addr
// (0 addresses_only, 1 port_seed). addresses_only is sampled when the IP
// protocol is decided; port_seed at the last byte.
// Reset (rst_n low, synchronous) clears parser state, the queue, the pipeline
// and both registers. A stalled result holds on the out_ channel.
module packet_header_symmetric_hash import phsh_pkg::*; #(
  parameter int unsigned MAX_NEST = DefaultMaxNest
) (
  input  logic       clk,
  input  logic       rst_n,
  phsh_stream_if.sink   in_s,
  phsh_stream_if.source out_s,
  input  logic       cfg_we,
  input  logic [0:0] cfg_addr,
  input  logic [7:0] cfg_data
);

  logic        addr_only_r;
  logic [7:0]  seed_r;
  logic        in_xfer;
  logic        tup_valid;
  tuple_t      tup, q_data;
  logic        q_full, q_empty, h_ready, q_pop;
  logic [31:0] hash_value;
  logic [1:0]  tuple_kind;
  logic        truncated;

  // Write configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_only_r <= 1'b0; seed_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_ADDRESSES_ONLY: addr_only_r <= cfg_data[0];
        CFG_PORT_SEED:      seed_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_s.ready = !q_full;
  assign in_xfer    = in_s.valid && in_s.ready;

  phsh_parser #(.MAX_NEST(MAX_NEST)) u_parser (
    .clk, .rst_n, .byte_valid(in_xfer), .data_byte(in_s.data[8:1]),
    .last_byte(in_s.data[0]), .addresses_only(addr_only_r), .port_seed(seed_r),
    .tuple_valid(tup_valid), .tuple_o(tup));

  assign q_pop = !q_empty && h_ready;

  phsh_queue u_queue (
    .clk, .rst_n, .push(tup_valid), .push_data(tup), .full(q_full),
    .pop(q_pop), .empty(q_empty), .pop_data(q_data));

  phsh_hasher u_hasher (
    .clk, .rst_n, .in_valid(!q_empty), .in_ready(h_ready), .tuple_i(q_data),
    .out_valid(out_s.valid), .out_ready(out_s.ready),
    .hash_value, .tuple_kind, .truncated);

  assign out_s.data = {hash_value, tuple_kind, truncated};

  // Queue never overflows or underflows, and results never carry tuple kind 3.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    tup_valid |-> !q_full) else $error("tuple queue overflow");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty) else $error("tuple queue underflow");
  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_s.valid |-> (tuple_kind != 2'd3)) else $error("bad tuple kind");

endmodule

// ----- src/phsh_parser.sv -----
// Front end: byte-wise header parser that emits one tuple per frame.
module phsh_parser import phsh_pkg::*; #(
  parameter int unsigned MAX_NEST = DefaultMaxNest
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        byte_valid,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic        addresses_only,
  input  logic [7:0]  port_seed,
  output logic        tuple_valid,
  output tuple_t      tuple_o
);

  phase_t      phase_r, phase_nxt;
  logic [10:0] off_r, off_nxt;
  logic [10:0] hstart_r, hstart_nxt;
  logic [3:0]  hwords_r, hwords_nxt;
  logic [15:0] proto_r, proto_nxt;
  logic [2:0]  depth_r, depth_nxt;
  logic [31:0] saddr_r, saddr_nxt, daddr_r, daddr_nxt;
  logic [15:0] sport_r, sport_nxt, dport_r, dport_nxt;
  logic [31:0] msrc_r, msrc_nxt, mdst_r, mdst_nxt;

  logic [10:0] rel;
  logic        here;
  logic [15:0] ptype;
  logic [7:0]  p8;
  logic [10:0] nstart;
  logic        v6;
  logic [31:0] s_f, d_f;
  logic [15:0] sp_f, dp_f;
  logic [1:0]  kind_f;
  logic        trunc_f;

  assign rel  = off_r - hstart_r;
  assign here = off_r >= hstart_r;

  always_comb begin
    phase_nxt = phase_r; off_nxt = off_r; hstart_nxt = hstart_r;
    hwords_nxt = hwords_r; proto_nxt = proto_r; depth_nxt = depth_r;
    saddr_nxt = saddr_r; daddr_nxt = daddr_r; sport_nxt = sport_r;
    dport_nxt = dport_r; msrc_nxt = msrc_r; mdst_nxt = mdst_r;
    ptype = 16'd0; p8 = 8'd0; nstart = 11'd0; v6 = 1'b0;
    s_f = '0; d_f = '0; sp_f = '0; dp_f = '0; kind_f = KIND_MAC; trunc_f = 1'b0;
    tuple_valid = 1'b0;
    if (byte_valid) begin
      // Per-phase parsing: ethertype dispatch in Ethernet and VLAN, then IP and ports.
      case (phase_r)
        PH_ETH: begin
          // Bytes 2..5 land in byte lanes 0..3: flipping bit 1 of the offset maps them.
          if (off_r >= 11'd2 && off_r <= 11'd5)
            mdst_nxt = mdst_r | (32'(data_byte) << (8 * (off_r[1:0] ^ 2'd2)));
          else if (off_r >= 11'd8 && off_r <= 11'd11)
            msrc_nxt = msrc_r | (32'(data_byte) << (8 * off_r[1:0]));
          else if (off_r == 11'd12) proto_nxt = {data_byte, 8'd0};
          else if (off_r == 11'd13) begin
            ptype = {proto_r[15:8], data_byte};
            proto_nxt = ptype;
            if (ptype == 16'h8100) phase_nxt = PH_VLAN;
            else if (ptype == 16'h0800) begin
              phase_nxt = PH_IP4; hstart_nxt = 11'd14; saddr_nxt = '0; daddr_nxt = '0;
            end else if (ptype == 16'h86DD) begin
              phase_nxt = PH_IP6; hstart_nxt = 11'd14; saddr_nxt = '0; daddr_nxt = '0;
            end else phase_nxt = PH_DONE_MAC;
          end
        end
        PH_VLAN: begin
          if (off_r == 11'd16) proto_nxt = {data_byte, 8'd0};
          else if (off_r == 11'd17) begin
            ptype = {proto_r[15:8], data_byte};
            proto_nxt = ptype;
            if (ptype == 16'h0800) begin
              phase_nxt = PH_IP4; hstart_nxt = 11'd18; saddr_nxt = '0; daddr_nxt = '0;
            end else if (ptype == 16'h86DD) begin
              phase_nxt = PH_IP6; hstart_nxt = 11'd18; saddr_nxt = '0; daddr_nxt = '0;
            end else phase_nxt = PH_DONE_MAC;
          end
        end
        PH_IP4, PH_IP6: begin
          if (here) begin
            v6 = (phase_r == PH_IP6);
            if (!v6 && rel == 11'd0)
              hwords_nxt = (data_byte[3:0] < 4'd5) ? 4'd5 : data_byte[3:0];
            else if ((!v6 && rel == 11'd9) || (v6 && rel == 11'd6))
              proto_nxt = {8'd0, data_byte};
            else if ((!v6 && rel >= 11'd12 && rel <= 11'd15) ||
                     (v6 && rel >= 11'd8 && rel <= 11'd11))
              saddr_nxt = saddr_r | (32'(data_byte) << (8 * (2'd3 - rel[1:0])));
            else if ((!v6 && rel >= 11'd16 && rel <= 11'd19) ||
                     (v6 && rel >= 11'd24 && rel <= 11'd27)) begin
              daddr_nxt = daddr_r | (32'(data_byte) << (8 * (2'd3 - rel[1:0])));
              if (rel[1:0] == 2'd3) begin
                p8 = proto_r[7:0];
                nstart = v6 ? hstart_r + 11'd40 : hstart_r + {5'd0, hwords_r, 2'd0};
                if (addresses_only) phase_nxt = PH_DONE_ADDR;
                else if (p8 == 8'd6 || p8 == 8'd17) begin
                  phase_nxt = PH_PORTS; hstart_nxt = nstart;
                  sport_nxt = '0; dport_nxt = '0;
                end else if (p8 == 8'd4 && 32'(depth_r) < MAX_NEST) begin
                  depth_nxt = depth_r + 3'd1; phase_nxt = PH_IP4; hstart_nxt = nstart;
                  saddr_nxt = '0; daddr_nxt = '0;
                end else if (p8 == 8'd41 && v6 && 32'(depth_r) < MAX_NEST) begin
                  depth_nxt = depth_r + 3'd1; phase_nxt = PH_IP6; hstart_nxt = nstart;
                  saddr_nxt = '0; daddr_nxt = '0;
                end else phase_nxt = PH_DONE_ADDR;
              end
            end
          end
        end
        PH_PORTS: begin
          if (here) begin
            if (rel <= 11'd1)
              sport_nxt = sport_r | (16'(data_byte) << (8 * (1 - rel[0])));
            else if (rel <= 11'd3) begin
              dport_nxt = dport_r | (16'(data_byte) << (8 * (1 - rel[0])));
              if (rel == 11'd3) phase_nxt = PH_DONE_PORTS;
            end
          end
        end
        default: ;
      endcase
      if (off_r != 11'd2047) off_nxt = off_r + 11'd1;

      // Build the tuple from the updated state at frame end.
      if (last_byte) begin
        tuple_valid = 1'b1;
        case (phase_nxt)
          PH_ETH, PH_VLAN, PH_DONE_MAC: begin
            s_f = msrc_nxt; d_f = mdst_nxt; sp_f = DEF_SRC_PORT; dp_f = DEF_DST_PORT;
            kind_f = KIND_MAC; trunc_f = (phase_nxt != PH_DONE_MAC);
          end
          PH_IP4, PH_IP6, PH_DONE_ADDR: begin
            s_f = saddr_nxt; d_f = daddr_nxt; sp_f = DEF_SRC_PORT; dp_f = DEF_DST_PORT;
            kind_f = KIND_ADDR; trunc_f = (phase_nxt != PH_DONE_ADDR);
          end
          default: begin
            s_f = saddr_nxt; d_f = daddr_nxt; sp_f = sport_nxt; dp_f = dport_nxt;
            kind_f = KIND_PORTS; trunc_f = (phase_nxt != PH_DONE_PORTS);
          end
        endcase
        phase_nxt = PH_ETH; off_nxt = '0; hstart_nxt = '0; hwords_nxt = '0;
        proto_nxt = '0; depth_nxt = '0; saddr_nxt = '0; daddr_nxt = '0;
        sport_nxt = '0; dport_nxt = '0; msrc_nxt = '0; mdst_nxt = '0;
      end
    end
    tuple_o.src_addr  = s_f;
    tuple_o.dst_addr  = d_f;
    tuple_o.src_port  = sp_f + {8'd0, port_seed};
    tuple_o.dst_port  = dp_f + {8'd0, port_seed};
    tuple_o.kind      = kind_f;
    tuple_o.truncated = trunc_f;
  end

  // Advance parse state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_ETH; off_r <= '0; hstart_r <= '0; hwords_r <= '0;
      proto_r <= '0; depth_r <= '0; saddr_r <= '0; daddr_r <= '0;
      sport_r <= '0; dport_r <= '0; msrc_r <= '0; mdst_r <= '0;
    end else begin
      phase_r <= phase_nxt; off_r <= off_nxt; hstart_r <= hstart_nxt;
      hwords_r <= hwords_nxt; proto_r <= proto_nxt; depth_r <= depth_nxt;
      saddr_r <= saddr_nxt; daddr_r <= daddr_nxt; sport_r <= sport_nxt;
      dport_r <= dport_nxt; msrc_r <= msrc_nxt; mdst_r <= mdst_nxt;
    end
  end

endmodule

// ----- src/phsh_queue.sv -----
// Small tuple queue between parser and hash engine.
module phsh_queue import phsh_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  tuple_t push_data,
  output logic   full,
  input  logic   pop,
  output logic   empty,
  output tuple_t pop_data
);

  localparam int unsigned AW = $clog2(QueueDepth);

  tuple_t        mem_r [QueueDepth];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  assign full     = (cnt_r == (AW+1)'(QueueDepth));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rp_r];

  // Store entries.
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  // Advance pointers and count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule

// ----- src/phsh_hasher.sv -----
// Back end: two-stage Toeplitz hash: XOR stage register, then output register.
module phsh_hasher import phsh_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  tuple_t      tuple_i,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] hash_value,
  output logic [1:0]  tuple_kind,
  output logic        truncated
);

  logic [95:0] bits;
  logic [31:0] part_a, part_b;
  logic        s1_valid_r;
  logic [31:0] s1_a_r, s1_b_r;
  logic [1:0]  s1_kind_r;
  logic        s1_trunc_r;
  logic        s1_adv;
  logic        o_valid_r;

  assign bits = {tuple_i.src_addr, tuple_i.dst_addr, tuple_i.src_port, tuple_i.dst_port};

  // XOR key windows for set tuple bits, in two halves.
  always_comb begin
    part_a = '0;
    part_b = '0;
    for (int unsigned i = 0; i < KeyWindows / 2; i++) begin
      if (bits[95-i]) part_a = part_a ^ key_window(i);
      if (bits[47-i]) part_b = part_b ^ key_window(i + KeyWindows / 2);
    end
  end

  assign s1_adv   = s1_valid_r && (!o_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_valid_r <= 1'b0;
    else if (in_ready) s1_valid_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_a_r <= part_a; s1_b_r <= part_b;
      s1_kind_r <= tuple_i.kind; s1_trunc_r <= tuple_i.truncated;
    end
  end

  // Hold result until taken.
  always_ff @(posedge clk) begin
    if (!rst_n) o_valid_r <= 1'b0;
    else if (!o_valid_r || out_ready) o_valid_r <= s1_valid_r;
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      hash_value <= s1_a_r ^ s1_b_r;
      tuple_kind <= s1_kind_r;
      truncated  <= s1_trunc_r;
    end
  end

  assign out_valid = o_valid_r;

endmodule
